/* design/sfir_pkg.sv */
// Shared constants, types and the control store of the stereo FIR filter.
package sfir_pkg;

   localparam int TAPS_MAX    = 64;
   localparam int ADDR_W      = $clog2(TAPS_MAX);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int SAMPLE_BITS = 16;
   localparam int PROD_W      = 2 * SAMPLE_BITS;
   localparam int ACC_W       = PROD_W + ADDR_W;
   localparam int GROUPS_MAX  = TAPS_MAX / 4;
   localparam int CSR_DATA_W  = 5;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [PROD_W-1:0]      prod_type;
   typedef logic signed [ACC_W-1:0]       acc_type;
   typedef logic [ADDR_W-1:0]             addr_type;
   typedef logic [1:0]                    csr_addr_type;

   localparam acc_type SAT_HI = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam acc_type SAT_LO = -SAT_HI - ACC_W'(1);

   // register indexes
   localparam csr_addr_type REG_TAP_GROUPS   = 2'd0;
   localparam csr_addr_type REG_RESULT_SHIFT = 2'd1;
   localparam csr_addr_type REG_STEREO_MODE  = 2'd2;

   // operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   typedef struct packed {
      sample_type left;
      sample_type right;
   } hist_word_type;

   typedef enum logic [2:0] {
      JC_NEXT,
      JC_ALWAYS,
      JC_NO_SAMPLE,
      JC_SHORT,
      JC_MORE_TAPS,
      JC_OUT_BUSY
   } jump_cond_type;

   typedef logic [2:0] step_type;

   localparam step_type STEP_FETCH  = 3'd0;
   localparam step_type STEP_CHECK  = 3'd1;
   localparam step_type STEP_MAC    = 3'd2;
   localparam step_type STEP_DRAIN0 = 3'd3;
   localparam step_type STEP_DRAIN1 = 3'd4;
   localparam step_type STEP_SHIFT  = 3'd5;
   localparam step_type STEP_OUT    = 3'd6;
   localparam step_type STEP_RET    = 3'd7;

   typedef struct packed {
      logic          take_req;
      logic          start;
      logic          rd;
      logic          shift;
      logic          out;
      jump_cond_type cond;
      step_type      target;
   } ucode_type;

   // control store: jump to target when cond holds, else fall through
   function automatic ucode_type ucode_rom(step_type pc);
      ucode_type uc;
      uc = '{take_req: 1'b0, start: 1'b0, rd: 1'b0, shift: 1'b0, out: 1'b0,
             cond: JC_NEXT, target: STEP_FETCH};
      case (pc)
         STEP_FETCH: begin
            uc.take_req = 1'b1;
            uc.cond     = JC_NO_SAMPLE;
            uc.target   = STEP_FETCH;
         end
         STEP_CHECK: begin
            uc.start  = 1'b1;
            uc.cond   = JC_SHORT;
            uc.target = STEP_FETCH;
         end
         STEP_MAC: begin
            uc.rd     = 1'b1;
            uc.cond   = JC_MORE_TAPS;
            uc.target = STEP_MAC;
         end
         STEP_DRAIN0: uc.cond = JC_NEXT;
         STEP_DRAIN1: uc.cond = JC_NEXT;
         STEP_SHIFT:  uc.shift = 1'b1;
         STEP_OUT: begin
            uc.out    = 1'b1;
            uc.cond   = JC_OUT_BUSY;
            uc.target = STEP_OUT;
         end
         STEP_RET: begin
            uc.cond   = JC_ALWAYS;
            uc.target = STEP_FETCH;
         end
         default: uc.cond = JC_ALWAYS;
      endcase
      return uc;
   endfunction

   function automatic sample_type saturate(acc_type v);
      sample_type r;
      if (v < SAT_LO) begin
         r = SAT_LO[SAMPLE_BITS-1:0];
      end else if (v > SAT_HI) begin
         r = SAT_HI[SAMPLE_BITS-1:0];
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

endpackage

/* design/stereo_fir_filter_saturating.sv */
// Stereo FIR filter with saturation, run by a small microcoded sequencer.
//
// Request channel (req_*): one word per handshake. operation = load writes
// coef_value at coef_index; operation = sample pushes left_in/right_in into
// the history. Response channel (rsp_*): one filtered frame per sample word
// once the history holds 4 * tap_groups frames (tap_groups 0 counts as 1,
// above 16 as 16). Config channel (csr_*): csr_ready is always high; write
// only while the block is idle. A load uses only the fetch step; a sample
// word without a result, the fetch and check steps; one with a result runs
// a single multiply-accumulate pass (one tap per cycle, both channels in
// parallel) over the coefficient and history memories through a 3-stage
// read/multiply/accumulate pipe, then a shift step and an output step.
// Reset (synchronous, active high) clears the fill count, coefficient
// valid bits (unwritten coefficients read as zero) and registers to
// tap_groups = 1, result_shift = 0, stereo_mode = 1. No clearing pass.
// The result sits in an output register; the next word is taken while it
// waits, and the sequencer only stalls when a second result is ready and
// rsp_ready is still low.
module stereo_fir_filter_saturating (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_operation,
   input  logic [5:0]                     req_coef_index,
   input  sfir_pkg::sample_type           req_coef_value,
   input  sfir_pkg::sample_type           req_left_in,
   input  sfir_pkg::sample_type           req_right_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output sfir_pkg::sample_type           rsp_left_out,
   output sfir_pkg::sample_type           rsp_right_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  sfir_pkg::csr_addr_type         csr_index,
   input  logic [sfir_pkg::CSR_DATA_W-1:0] csr_data
);
   import sfir_pkg::*;

   // memories
   sample_type    coef_mem [TAPS_MAX];
   hist_word_type hist_mem [TAPS_MAX];
   logic [TAPS_MAX-1:0] coef_vld_ff, coef_vld_in;

   // config
   logic [4:0] tap_groups_ff, tap_groups_in;
   logic [4:0] shift_ff, shift_in;
   logic       stereo_ff, stereo_in;

   // sequencer
   step_type  pc_ff, pc_in;
   ucode_type uc;
   logic      jump;

   logic [CNT_W-1:0] fill_ff, fill_in;
   addr_type wp_ff, wp_in;
   addr_type rd_addr_ff, rd_addr_in;
   addr_type idx_ff, idx_in;

   // datapath
   hist_word_type hist_rd_ff;
   sample_type    coef_rd_ff;
   logic          coef_ok_ff;
   logic          rd_vld_ff, prod_vld_ff;
   prod_type      prod_l_ff, prod_l_in, prod_r_ff, prod_r_in;
   acc_type       acc_l_ff, acc_l_in, acc_r_ff, acc_r_in;
   acc_type       shl_l_ff, shl_l_in, shl_r_ff, shl_r_in;
   sample_type    rsp_left_ff, rsp_left_in, rsp_right_ff, rsp_right_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic             req_fire, is_sample, csr_fire, out_busy, out_load;
   logic [4:0]       groups;
   logic [CNT_W-1:0] taps;
   addr_type         taps_m1;
   logic             short_hist, last_tap;
   sample_type       coef_eff, hist_left, hist_right;

   assign uc        = ucode_rom(pc_ff);
   assign req_ready = uc.take_req;
   assign req_fire  = req_valid & req_ready;
   assign is_sample = (req_operation == OP_SAMPLE);
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_left_ff;
   assign rsp_right_out = rsp_right_ff;

   always_comb begin
      if (tap_groups_ff == 5'd0) begin
         groups = 5'd1;
      end else if (tap_groups_ff > 5'(GROUPS_MAX)) begin
         groups = 5'(GROUPS_MAX);
      end else begin
         groups = tap_groups_ff;
      end
   end

   assign taps       = CNT_W'(groups) << 2;
   assign taps_m1    = ADDR_W'(taps - CNT_W'(1));
   assign short_hist = (fill_ff < taps);
   assign last_tap   = (idx_ff == taps_m1);
   assign out_busy   = rsp_valid_ff & ~rsp_ready;
   assign out_load   = uc.out & ~out_busy;

   always_comb begin
      case (uc.cond)
         JC_NEXT:      jump = 1'b0;
         JC_ALWAYS:    jump = 1'b1;
         JC_NO_SAMPLE: jump = ~(req_fire & is_sample);
         JC_SHORT:     jump = short_hist;
         JC_MORE_TAPS: jump = ~last_tap;
         JC_OUT_BUSY:  jump = out_busy;
         default:      jump = 1'b1;
      endcase
      pc_in = jump ? uc.target : pc_ff + 3'd1;
   end

   // config writes
   always_comb begin
      tap_groups_in = tap_groups_ff;
      shift_in      = shift_ff;
      stereo_in     = stereo_ff;
      if (csr_fire) begin
         case (csr_index)
            REG_TAP_GROUPS:   tap_groups_in = csr_data[4:0];
            REG_RESULT_SHIFT: shift_in      = csr_data[4:0];
            REG_STEREO_MODE:  stereo_in     = csr_data[0];
            default: ;
         endcase
      end
   end

   // history bookkeeping and read addressing
   always_comb begin
      wp_in       = wp_ff;
      fill_in     = fill_ff;
      coef_vld_in = coef_vld_ff;
      rd_addr_in  = rd_addr_ff;
      idx_in      = idx_ff;
      if (req_fire && is_sample) begin
         wp_in = wp_ff + addr_type'(1);
         if (fill_ff < CNT_W'(TAPS_MAX)) begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end
      if (req_fire && !is_sample) begin
         coef_vld_in[req_coef_index] = 1'b1;
      end
      if (uc.start) begin
         // oldest sample of the window; wraps to wp when the window spans all 64 entries
         rd_addr_in = wp_ff - taps[ADDR_W-1:0];
         idx_in     = '0;
      end else if (uc.rd) begin
         rd_addr_in = rd_addr_ff + addr_type'(1);
         idx_in     = idx_ff + addr_type'(1);
      end
   end

   // multiply-accumulate pipe
   always_comb begin
      coef_eff   = coef_ok_ff ? coef_rd_ff : '0;
      hist_left  = $signed(hist_rd_ff.left);
      hist_right = $signed(hist_rd_ff.right);
      prod_l_in  = PROD_W'(coef_eff) * PROD_W'(hist_left);
      prod_r_in  = PROD_W'(coef_eff) * PROD_W'(hist_right);
      acc_l_in   = acc_l_ff;
      acc_r_in   = acc_r_ff;
      if (uc.start) begin
         acc_l_in = '0;
         acc_r_in = '0;
      end else if (prod_vld_ff) begin
         acc_l_in = acc_l_ff + ACC_W'(prod_l_ff);
         acc_r_in = acc_r_ff + ACC_W'(prod_r_ff);
      end
      shl_l_in = acc_l_ff >>> shift_ff;
      shl_r_in = acc_r_ff >>> shift_ff;
   end

   // output register
   always_comb begin
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (out_load) begin
         rsp_left_in  = saturate(shl_l_ff);
         rsp_right_in = stereo_ff ? saturate(shl_r_ff) : '0;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= STEP_FETCH;
         tap_groups_ff <= 5'd1;
         shift_ff      <= 5'd0;
         stereo_ff     <= 1'b1;
         fill_ff       <= '0;
         wp_ff         <= '0;
         coef_vld_ff   <= '0;
         rd_vld_ff     <= 1'b0;
         prod_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pc_ff         <= pc_in;
         tap_groups_ff <= tap_groups_in;
         shift_ff      <= shift_in;
         stereo_ff     <= stereo_in;
         fill_ff       <= fill_in;
         wp_ff         <= wp_in;
         coef_vld_ff   <= coef_vld_in;
         rd_vld_ff     <= uc.rd;
         prod_vld_ff   <= rd_vld_ff;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff   <= rd_addr_in;
      idx_ff       <= idx_in;
      prod_l_ff    <= prod_l_in;
      prod_r_ff    <= prod_r_in;
      acc_l_ff     <= acc_l_in;
      acc_r_ff     <= acc_r_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      if (uc.shift) begin
         shl_l_ff <= shl_l_in;
         shl_r_ff <= shl_r_in;
      end
   end

   // coefficient memory
   always_ff @(posedge clock) begin
      if (req_fire && !is_sample) begin
         coef_mem[req_coef_index] <= req_coef_value;
      end
      if (uc.rd) begin
         coef_rd_ff <= coef_mem[idx_ff];
         coef_ok_ff <= coef_vld_ff[idx_ff];
      end
   end

   // history memory, left and right in one word; mono pushes zero on the right
   always_ff @(posedge clock) begin
      if (req_fire && is_sample) begin
         hist_mem[wp_ff] <= '{left: req_left_in,
                              right: stereo_ff ? req_right_in : '0};
      end
      if (uc.rd) begin
         hist_rd_ff <= hist_mem[rd_addr_ff];
      end
   end

endmodule
